FILE: src/multi_click_dual_hold_buttons_macros.svh
// Assertion macros shared by the checker file of the button front end.
`ifndef MULTI_CLICK_DUAL_HOLD_BUTTONS_MACROS_SVH
`define MULTI_CLICK_DUAL_HOLD_BUTTONS_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define MCDHB_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("button front end: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define MCDHB_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("button front end: next-cycle check failed");

`endif

FILE: src/mcdhb_pkg.sv
// Shared types and constants of the two-button front end.
package mcdhb_pkg;

    localparam int TIMER_BITS_DEF = 16;
    localparam int CFG_W          = 16;
    localparam int CFG_IDX_W      = 2;
    localparam int CLICK_W        = 8;

    localparam logic [CFG_W-1:0] DEBOUNCE_RST = 16'd30;
    localparam logic [CFG_W-1:0] CLICK_GAP_RST = 16'd420;
    localparam logic [CFG_W-1:0] SYNC_WINDOW_RST = 16'd450;
    localparam logic [CFG_W-1:0] HOLD_RST = 16'd1200;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DEBOUNCE    = 2'd0,
        CFG_CLICK_GAP   = 2'd1,
        CFG_SYNC_WINDOW = 2'd2,
        CFG_HOLD        = 2'd3
    } cfg_idx_t;

    typedef struct packed {
        logic [CFG_W-1:0] debounce;
        logic [CFG_W-1:0] click_gap;
        logic [CFG_W-1:0] sync_window;
        logic [CFG_W-1:0] hold;
    } cfg_t;

    typedef struct packed {
        logic               valid;
        logic [CLICK_W-1:0] count;
    } click_rpt_t;

endpackage

FILE: src/multi_click_dual_hold_buttons.sv
// Top level of the two-button debounce, multi-click and dual-hold front end.
//
// Usage:
//   Input channel: one word per millisecond tick, carrying the raw active-low
//   levels level_a and level_b, moved by in_valid / in_stall.
//   Output channel: one word per input word with the click reports of both
//   buttons and the dual-hold toggle pulse, moved by out_valid / out_stall.
//   Configuration channel: cfg_valid / cfg_ready with cfg_index selecting
//   debounce, click gap, sync window or hold time; cfg_ready is always high.
//   Write it only while no word is in flight.
// Timing:
//   out_valid rises in the cycle after input acceptance. One word is accepted
//   every cycle while in_stall is low; the output register alone sets that rate,
//   since all timer and counter updates complete in the accepting cycle.
// Reset:
//   rst_n clears all timers, counts and flags, loads the default times and
//   empties the output register.
// Backpressure:
//   While out_stall holds a waiting word, in_stall is raised and no input word
//   is taken; the word is accepted again in the cycle the output drains.
module multi_click_dual_hold_buttons #(
    parameter int TIMER_BITS = mcdhb_pkg::TIMER_BITS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [mcdhb_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [mcdhb_pkg::CFG_W-1:0]     cfg_data,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic                            level_a,
    input  logic                            level_b,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic                            clicks_a_valid,
    output logic [mcdhb_pkg::CLICK_W-1:0]   clicks_a,
    output logic                            clicks_b_valid,
    output logic [mcdhb_pkg::CLICK_W-1:0]   clicks_b,
    output logic                            hold_toggle
);
    import mcdhb_pkg::*;

    cfg_t       cfg_reg;
    click_rpt_t rpt_a, rpt_b;
    logic       toggle;
    logic       accept;

    logic               out_valid_reg, out_valid_next;
    click_rpt_t         rpt_a_reg, rpt_b_reg;
    logic               toggle_reg;

    // Configuration registers; the port never pushes back.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.debounce    <= DEBOUNCE_RST;
            cfg_reg.click_gap   <= CLICK_GAP_RST;
            cfg_reg.sync_window <= SYNC_WINDOW_RST;
            cfg_reg.hold        <= HOLD_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_DEBOUNCE:    cfg_reg.debounce    <= cfg_data;
                CFG_CLICK_GAP:   cfg_reg.click_gap   <= cfg_data;
                CFG_SYNC_WINDOW: cfg_reg.sync_window <= cfg_data;
                CFG_HOLD:        cfg_reg.hold        <= cfg_data;
                default:         cfg_reg             <= cfg_reg;
            endcase
        end
    end

    // Stall the input only while a finished word waits on a stalled receiver.
    assign in_stall = out_valid_reg && out_stall;
    assign accept   = in_valid && !in_stall;

    // Per-button debounce and click counting; state advances on each accepted word.
    mcdhb_button #(.TIMER_BITS(TIMER_BITS)) u_button_a (
        .clk    (clk),
        .rst_n  (rst_n),
        .en     (accept),
        .raw    (level_a),
        .cfg    (cfg_reg),
        .report (rpt_a)
    );

    mcdhb_button #(.TIMER_BITS(TIMER_BITS)) u_button_b (
        .clk    (clk),
        .rst_n  (rst_n),
        .en     (accept),
        .raw    (level_b),
        .cfg    (cfg_reg),
        .report (rpt_b)
    );

    // Dual-hold detector looks at both raw levels together.
    mcdhb_hold #(.TIMER_BITS(TIMER_BITS)) u_hold (
        .clk    (clk),
        .rst_n  (rst_n),
        .en     (accept),
        .raw_a  (level_a),
        .raw_b  (level_b),
        .cfg    (cfg_reg),
        .toggle (toggle)
    );

    // Output register: load on accept, hold while stalled, drop once taken.
    always_comb
    begin
        if (accept)
            out_valid_next = 1'b1;
        else if (out_stall)
            out_valid_next = out_valid_reg;
        else
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            rpt_a_reg  <= rpt_a;
            rpt_b_reg  <= rpt_b;
            toggle_reg <= toggle;
        end
    end

    assign out_valid      = out_valid_reg;
    assign clicks_a_valid = rpt_a_reg.valid;
    assign clicks_a       = rpt_a_reg.count;
    assign clicks_b_valid = rpt_b_reg.valid;
    assign clicks_b       = rpt_b_reg.count;
    assign hold_toggle    = toggle_reg;

endmodule

FILE: src/mcdhb_button.sv
// Debouncer and multi-click counter for one button.
module mcdhb_button #(
    parameter int TIMER_BITS = mcdhb_pkg::TIMER_BITS_DEF
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    en,
    input  logic                    raw,
    input  mcdhb_pkg::cfg_t         cfg,
    output mcdhb_pkg::click_rpt_t   report
);
    import mcdhb_pkg::*;

    localparam int CMP_W = (TIMER_BITS > CFG_W) ? TIMER_BITS : CFG_W;

    logic                  last_raw_reg;
    logic                  stable_reg, stable_next;
    logic [TIMER_BITS-1:0] since_change_reg, since_change_next;
    logic [TIMER_BITS-1:0] since_click_reg, since_click_next;
    logic [CLICK_W-1:0]    count_reg, count_next;

    logic [TIMER_BITS-1:0] click_age;
    logic [CLICK_W-1:0]    count_upd;
    logic                  settle;
    logic                  release_evt;
    logic                  fire;

    always_comb
    begin
        // restart the settle timer on any raw edge
        if (raw != last_raw_reg)
            since_change_next = '0;
        else if (since_change_reg == '1)
            since_change_next = since_change_reg;
        else
            since_change_next = since_change_reg + 1'b1;

        click_age = (since_click_reg == '1) ? since_click_reg : since_click_reg + 1'b1;

        settle = (CMP_W'(since_change_next) > CMP_W'(cfg.debounce)) && (raw != stable_reg);
        stable_next = settle ? raw : stable_reg;
        release_evt = settle && raw;

        count_upd = (release_evt && count_reg != '1) ? count_reg + 1'b1 : count_reg;
        since_click_next = release_evt ? '0 : click_age;

        fire = (count_upd != '0) && (CMP_W'(since_click_next) > CMP_W'(cfg.click_gap));
        count_next = fire ? '0 : count_upd;

        report.valid = fire;
        report.count = fire ? count_upd : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_raw_reg     <= 1'b1;
            stable_reg       <= 1'b1;
            since_change_reg <= '0;
            since_click_reg  <= '0;
            count_reg        <= '0;
        end
        else if (en)
        begin
            last_raw_reg     <= raw;
            stable_reg       <= stable_next;
            since_change_reg <= since_change_next;
            since_click_reg  <= since_click_next;
            count_reg        <= count_next;
        end
    end

endmodule

FILE: src/mcdhb_hold.sv
// Synchronized dual-hold detector working on the raw levels of both buttons.
module mcdhb_hold #(
    parameter int TIMER_BITS = mcdhb_pkg::TIMER_BITS_DEF
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            en,
    input  logic            raw_a,
    input  logic            raw_b,
    input  mcdhb_pkg::cfg_t cfg,
    output logic            toggle
);
    import mcdhb_pkg::*;

    localparam int CMP_W = (TIMER_BITS > CFG_W) ? TIMER_BITS : CFG_W;

    logic                  active_a_reg, active_b_reg;
    logic [TIMER_BITS-1:0] age_a_reg, age_a_next;
    logic [TIMER_BITS-1:0] age_b_reg, age_b_next;
    logic                  running_reg, running_next;
    logic                  fired_reg, fired_next;
    logic [TIMER_BITS-1:0] hold_age_reg, hold_age_next;

    logic [TIMER_BITS-1:0] hold_age_inc;
    logic [TIMER_BITS-1:0] delta;
    logic                  both;

    always_comb
    begin
        // press ages restart on the first pressed tick
        if (!raw_a && !active_a_reg)
            age_a_next = '0;
        else
            age_a_next = (age_a_reg == '1) ? age_a_reg : age_a_reg + 1'b1;
        if (!raw_b && !active_b_reg)
            age_b_next = '0;
        else
            age_b_next = (age_b_reg == '1) ? age_b_reg : age_b_reg + 1'b1;

        hold_age_inc = (hold_age_reg == '1) ? hold_age_reg : hold_age_reg + 1'b1;
        delta = (age_a_next > age_b_next) ? age_a_next - age_b_next : age_b_next - age_a_next;
        both = !raw_a && !raw_b && (CMP_W'(delta) <= CMP_W'(cfg.sync_window));

        toggle        = 1'b0;
        running_next  = 1'b0;
        fired_next    = 1'b0;
        hold_age_next = hold_age_inc;
        if (both)
        begin
            running_next  = 1'b1;
            hold_age_next = running_reg ? hold_age_inc : '0;
            fired_next    = fired_reg;
            if (!fired_reg && CMP_W'(hold_age_next) >= CMP_W'(cfg.hold))
            begin
                toggle     = 1'b1;
                fired_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_a_reg <= 1'b0;
            active_b_reg <= 1'b0;
            age_a_reg    <= '0;
            age_b_reg    <= '0;
            running_reg  <= 1'b0;
            fired_reg    <= 1'b0;
            hold_age_reg <= '0;
        end
        else if (en)
        begin
            active_a_reg <= !raw_a;
            active_b_reg <= !raw_b;
            age_a_reg    <= age_a_next;
            age_b_reg    <= age_b_next;
            running_reg  <= running_next;
            fired_reg    <= fired_next;
            hold_age_reg <= hold_age_next;
        end
    end

endmodule

FILE: src/multi_click_dual_hold_buttons_checker.sv
// Port-level checker of the button front end, bound to its top level.
`include "multi_click_dual_hold_buttons_macros.svh"

module multi_click_dual_hold_buttons_checker (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            in_valid,
    input logic                            in_stall,
    input logic                            out_valid,
    input logic                            out_stall,
    input logic                            clicks_a_valid,
    input logic [mcdhb_pkg::CLICK_W-1:0]   clicks_a,
    input logic                            clicks_b_valid,
    input logic [mcdhb_pkg::CLICK_W-1:0]   clicks_b
);

    // a stalled word stays offered
    `MCDHB_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid)

    // input is held back only by a waiting, stalled word
    `MCDHB_IMPLY(a_stall_cause, clk, rst_n, in_stall, out_valid && out_stall)

    // every accepted word shows up in the next cycle
    `MCDHB_NEXT(a_accept_out, clk, rst_n, in_valid && !in_stall, out_valid)

    // a reported count is nonzero, an absent one reads zero
    `MCDHB_IMPLY(a_count_a, clk, rst_n, out_valid, clicks_a_valid == (clicks_a != 8'd0))
    `MCDHB_IMPLY(a_count_b, clk, rst_n, out_valid, clicks_b_valid == (clicks_b != 8'd0))

endmodule

bind multi_click_dual_hold_buttons multi_click_dual_hold_buttons_checker u_checker (.*);
